// ----- hdl/assert_macros.svh -----
// Assertion macros for the RTL of the mask bitmap writer.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked on every rising edge outside reset.
`define CMBW_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, checked on every rising edge outside reset.
`define CMBW_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define CMBW_ASSERT_IMP(label, ante, cons)
`define CMBW_ASSERT_NXT(label, ante, cons)

`endif

`endif

// ----- hdl/cmbw_pkg.sv -----
// Shared constants, codes and payload types of the mask bitmap writer.
`timescale 1ns / 1ps

package cmbw_pkg;

    // Default mask geometry.
    localparam int MASK_WIDTH_DEF  = 1024;
    localparam int MASK_HEIGHT_DEF = 128;
    localparam int ROW_WORDS_DEF   = 32;
    localparam int MASK_WORDS_DEF  = 4096;

    // Wide enough for any row * ROW_WORDS + word within the parameter ranges.
    localparam int WIDX_W = 20;

    localparam int CFG_ADDR_W = 5;
    localparam int CFG_DATA_W = 32;

    // Input operation codes.
    localparam logic OP_BYTE  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Register indexes (byte address is four times the index).
    localparam logic [2:0] REG_DEST_X        = 3'd0;
    localparam logic [2:0] REG_DEST_Y        = 3'd1;
    localparam logic [2:0] REG_BITMAP_WIDTH  = 3'd2;
    localparam logic [2:0] REG_BITMAP_HEIGHT = 3'd3;
    localparam logic [2:0] REG_ROW_STRIDE    = 3'd4;

    typedef logic [7:0]        src_byte_t;
    typedef logic [11:0]       word_idx_t;
    typedef logic [31:0]       word_t;
    typedef logic [WIDX_W-1:0] widx_t;

endpackage

// ----- hdl/cmbw_byte_if.sv -----
// Input channel: source bitmap bytes and clear-word operations.
`timescale 1ns / 1ps

interface cmbw_byte_if
    import cmbw_pkg::*;
();
    logic      valid;
    logic      ready;
    logic      opcode;
    logic      first_byte;
    src_byte_t source_byte;
    word_idx_t clear_index;

    modport source (
        output valid, opcode, first_byte, source_byte, clear_index,
        input  ready
    );

    modport sink (
        input  valid, opcode, first_byte, source_byte, clear_index,
        output ready
    );
endinterface

// ----- hdl/cmbw_word_if.sv -----
// Output channel: mask memory word writes.
`timescale 1ns / 1ps

interface cmbw_word_if
    import cmbw_pkg::*;
();
    logic      valid;
    logic      ready;
    word_idx_t word_addr;
    word_t     word_value;
    logic      last_write;

    modport source (
        output valid, word_addr, word_value, last_write,
        input  ready
    );

    modport sink (
        input  valid, word_addr, word_value, last_write,
        output ready
    );
endinterface

// ----- hdl/clipped_mask_bitmap_writer.sv -----
// Clipped 1bpp bitmap blitter into a 32-bit-word mask memory with a shadow copy.
//
// The src channel carries one transaction per source byte (opcode byte) or per
// clear-word request (opcode clear). The dst channel carries the mask writes:
// a source byte yields zero to two writes in ascending word order, and only for
// words whose contents change; a clear inside the mask yields one write of zero,
// one outside it none. last_write marks the final write of a transaction.
// Geometry is set through the APB port (dest_x, dest_y, bitmap_width,
// bitmap_height, row_stride at 4*index). After acceptance a source byte goes
// through geometry, then two reads of the mask shadow, an evaluation and the
// write-backs; the shadow sits in one single-port memory. The next transaction
// is accepted once the current one has handed all its writes to the output
// register, so a full output register holds it off while dst stalls.
// After reset the block zeroes the shadow one word per cycle with src.ready
// low; register writes are taken during that pass.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module clipped_mask_bitmap_writer
    import cmbw_pkg::*;
#(
    parameter int MASK_WIDTH  = MASK_WIDTH_DEF,
    parameter int MASK_HEIGHT = MASK_HEIGHT_DEF,
    parameter int ROW_WORDS   = ROW_WORDS_DEF,
    parameter int MASK_WORDS  = MASK_WORDS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    cmbw_byte_if.sink             src,
    cmbw_word_if.source           dst
);

    localparam int AW = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;

    localparam logic [3:0] ST_INIT     = 4'd0;
    localparam logic [3:0] ST_IDLE     = 4'd1;
    localparam logic [3:0] ST_GEOM     = 4'd2;
    localparam logic [3:0] ST_RD_LO    = 4'd3;
    localparam logic [3:0] ST_RD_HI    = 4'd4;
    localparam logic [3:0] ST_EVAL     = 4'd5;
    localparam logic [3:0] ST_EMIT_LO  = 4'd6;
    localparam logic [3:0] ST_EMIT_HI  = 4'd7;
    localparam logic [3:0] ST_CLR_EMIT = 4'd8;

    logic [3:0]    state_reg, state_next;

    // Configuration registers.
    logic [12:0]   dest_x_reg;
    logic [12:0]   dest_y_reg;
    logic [13:0]   width_reg;
    logic [12:0]   height_reg;
    logic [10:0]   stride_reg;

    // Source position.
    logic [12:0]   row_pos_reg;
    logic [9:0]    byte_pos_reg;

    // Per-transaction registers.
    src_byte_t     sb_reg;
    logic [12:0]   col0_reg;
    logic [15:0]   dx0_reg;
    logic [15:0]   dy_reg;
    logic          row_in_reg;
    word_idx_t     ci_reg;
    word_t         mask_lo_reg, val_lo_reg, mask_hi_reg, val_hi_reg;
    widx_t         widx_lo_reg, widx_hi_reg;
    word_t         new_lo_reg, new_hi_reg;
    logic          chg_lo_reg, chg_hi_reg;

    logic [AW-1:0] init_cnt_reg;

    // Output register.
    logic          out_valid_reg;
    word_idx_t     out_idx_reg;
    word_t         out_val_reg;
    logic          out_last_reg;

    // Shadow memory.
    word_t         shadow_mem [MASK_WORDS];
    word_t         rd_data_reg;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_addr;
    word_t         mem_wdata;

    logic          cfg_we;
    logic          in_fire;
    logic          out_free;
    logic          clr_in_range;
    logic          push;
    word_idx_t     push_idx;
    word_t         push_val;
    logic          push_last;

    logic [9:0]    bp_cur;
    logic [12:0]   row_cur;
    logic [10:0]   stride_eff;
    logic          wrap;
    logic [12:0]   row_pos_next;
    logic [9:0]    byte_pos_next;

    logic          dy_ok;
    logic [10:0]   lo_word, hi_word;
    widx_t         widx_lo, widx_hi;
    logic          lo_ok, hi_ok;
    word_t         mask_lo, val_lo, mask_hi, val_hi;
    logic [15:0]   dxk [8];
    logic [13:0]   colk [8];
    logic          pix_ok [8];
    word_t         merged;

    // ---------------------------------------------------------------------
    // Configuration port
    // ---------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dest_x_reg <= '0;
            dest_y_reg <= '0;
            width_reg  <= '0;
            height_reg <= '0;
            stride_reg <= 11'd1;
        end
        else if (cfg_we)
        begin
            unique case (paddr[4:2])
                REG_DEST_X:        dest_x_reg <= pwdata[12:0];
                REG_DEST_Y:        dest_y_reg <= pwdata[12:0];
                REG_BITMAP_WIDTH:  width_reg  <= pwdata[13:0];
                REG_BITMAP_HEIGHT: height_reg <= pwdata[12:0];
                REG_ROW_STRIDE:    stride_reg <= pwdata[10:0];
                default:           ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_DEST_X:        prdata = CFG_DATA_W'(dest_x_reg);
            REG_DEST_Y:        prdata = CFG_DATA_W'(dest_y_reg);
            REG_BITMAP_WIDTH:  prdata = CFG_DATA_W'(width_reg);
            REG_BITMAP_HEIGHT: prdata = CFG_DATA_W'(height_reg);
            REG_ROW_STRIDE:    prdata = CFG_DATA_W'(stride_reg);
            default:           prdata = '0;
        endcase
    end

    // ---------------------------------------------------------------------
    // Input side and source position
    // ---------------------------------------------------------------------
    assign src.ready    = (state_reg == ST_IDLE);
    assign in_fire      = src.valid && src.ready;
    assign out_free     = !out_valid_reg || dst.ready;
    assign clr_in_range = (17'(src.clear_index) < 17'(MASK_WORDS));

    always_comb
    begin
        bp_cur  = src.first_byte ? '0 : byte_pos_reg;
        row_cur = src.first_byte ? '0 : row_pos_reg;

        // Stride of zero behaves as one, anything past 1024 as 1024.
        if (stride_reg == 11'd0)
            stride_eff = 11'd1;
        else if (stride_reg > 11'd1024)
            stride_eff = 11'd1024;
        else
            stride_eff = stride_reg;

        wrap = ({1'b0, bp_cur} + 11'd1) >= stride_eff;
        if (wrap)
        begin
            byte_pos_next = '0;
            row_pos_next  = (row_cur != 13'h1FFF) ? row_cur + 13'd1 : row_cur;
        end
        else
        begin
            byte_pos_next = bp_cur + 10'd1;
            row_pos_next  = row_cur;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_pos_reg  <= '0;
            byte_pos_reg <= '0;
        end
        else if (in_fire && src.opcode == OP_BYTE)
        begin
            row_pos_reg  <= row_pos_next;
            byte_pos_reg <= byte_pos_next;
        end
    end

    // ---------------------------------------------------------------------
    // Geometry: split the byte's eight pixels over the two words it can touch
    // ---------------------------------------------------------------------
    always_comb
    begin
        dy_ok   = row_in_reg && !dy_reg[15] && (dy_reg < 16'(MASK_HEIGHT));
        lo_word = dx0_reg[15:5];
        hi_word = lo_word + 11'd1;
        widx_lo = WIDX_W'(dy_reg[11:0]) * WIDX_W'(ROW_WORDS) + WIDX_W'(lo_word[9:0]);
        widx_hi = WIDX_W'(dy_reg[11:0]) * WIDX_W'(ROW_WORDS) + WIDX_W'(hi_word[9:0]);
        lo_ok   = widx_lo < WIDX_W'(MASK_WORDS);
        hi_ok   = widx_hi < WIDX_W'(MASK_WORDS);
        mask_lo = '0;
        val_lo  = '0;
        mask_hi = '0;
        val_hi  = '0;
        for (int k = 0; k < 8; k++)
        begin
            dxk[k]    = dx0_reg + 16'(k);
            colk[k]   = {1'b0, col0_reg} + 14'(k);
            pix_ok[k] = dy_ok && (colk[k] < width_reg) && !dxk[k][15]
                        && (dxk[k] < 16'(MASK_WIDTH));
            // A pixel whose word differs from the first pixel's lands in the upper word.
            if (dxk[k][15:5] != lo_word)
            begin
                if (pix_ok[k] && hi_ok)
                begin
                    mask_hi[dxk[k][4:0]] = 1'b1;
                    val_hi[dxk[k][4:0]]  = sb_reg[3'(7 - k)];
                end
            end
            else if (pix_ok[k] && lo_ok)
            begin
                mask_lo[dxk[k][4:0]] = 1'b1;
                val_lo[dxk[k][4:0]]  = sb_reg[3'(7 - k)];
            end
        end
    end

    // Merge of the read word with the pending pixels of the word being evaluated.
    always_comb
    begin
        if (state_reg == ST_RD_HI)
            merged = (rd_data_reg & ~mask_lo_reg) | (val_lo_reg & mask_lo_reg);
        else
            merged = (rd_data_reg & ~mask_hi_reg) | (val_hi_reg & mask_hi_reg);
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            sb_reg     <= src.source_byte;
            ci_reg     <= src.clear_index;
            col0_reg   <= {bp_cur, 3'b000};
            dx0_reg    <= {{3{dest_x_reg[12]}}, dest_x_reg} + {3'b000, bp_cur, 3'b000};
            dy_reg     <= {{3{dest_y_reg[12]}}, dest_y_reg} + {3'b000, row_cur};
            row_in_reg <= (width_reg != 14'd0) && (row_cur < height_reg);
        end
        if (state_reg == ST_GEOM)
        begin
            mask_lo_reg <= mask_lo;
            val_lo_reg  <= val_lo;
            mask_hi_reg <= mask_hi;
            val_hi_reg  <= val_hi;
            widx_lo_reg <= widx_lo;
            widx_hi_reg <= widx_hi;
        end
        // An untouched word merges to its old value, so it never counts as changed.
        if (state_reg == ST_RD_HI)
        begin
            new_lo_reg <= merged;
            chg_lo_reg <= (merged != rd_data_reg);
        end
        if (state_reg == ST_EVAL)
        begin
            new_hi_reg <= merged;
            chg_hi_reg <= (merged != rd_data_reg);
        end
    end

    // ---------------------------------------------------------------------
    // Shadow memory: single port; the read data register sets the read latency
    // ---------------------------------------------------------------------
    always_comb
    begin
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_addr  = '0;
        mem_wdata = '0;
        unique case (state_reg)
            ST_INIT:
            begin
                mem_we   = 1'b1;
                mem_addr = init_cnt_reg;
            end
            ST_IDLE:
            begin
                mem_we   = in_fire && (src.opcode == OP_CLEAR) && clr_in_range;
                mem_addr = AW'(src.clear_index);
            end
            ST_RD_LO:
            begin
                mem_re   = 1'b1;
                mem_addr = widx_lo_reg[AW-1:0];
            end
            ST_RD_HI:
            begin
                mem_re   = 1'b1;
                mem_addr = widx_hi_reg[AW-1:0];
            end
            ST_EMIT_LO:
            begin
                mem_we    = chg_lo_reg && out_free;
                mem_addr  = widx_lo_reg[AW-1:0];
                mem_wdata = new_lo_reg;
            end
            ST_EMIT_HI:
            begin
                mem_we    = chg_hi_reg && out_free;
                mem_addr  = widx_hi_reg[AW-1:0];
                mem_wdata = new_hi_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            shadow_mem[mem_addr] <= mem_wdata;
        if (mem_re)
            rd_data_reg <= shadow_mem[mem_addr];
    end

    // ---------------------------------------------------------------------
    // Sequencer
    // ---------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:
                if (init_cnt_reg == AW'(MASK_WORDS - 1))
                    state_next = ST_IDLE;
            ST_IDLE:
                if (in_fire)
                begin
                    if (src.opcode == OP_BYTE)
                        state_next = ST_GEOM;
                    else if (clr_in_range)
                        state_next = ST_CLR_EMIT;
                end
            ST_GEOM:    state_next = ST_RD_LO;
            ST_RD_LO:   state_next = ST_RD_HI;
            ST_RD_HI:   state_next = ST_EVAL;
            ST_EVAL:    state_next = ST_EMIT_LO;
            ST_EMIT_LO:
                if (!chg_lo_reg || out_free)
                    state_next = ST_EMIT_HI;
            ST_EMIT_HI:
                if (!chg_hi_reg || out_free)
                    state_next = ST_IDLE;
            ST_CLR_EMIT:
                if (out_free)
                    state_next = ST_IDLE;
            default:    state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_INIT;
            init_cnt_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_INIT)
                init_cnt_reg <= init_cnt_reg + AW'(1);
        end
    end

    // ---------------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------------
    always_comb
    begin
        push      = 1'b0;
        push_idx  = ci_reg;
        push_val  = '0;
        push_last = 1'b1;
        unique case (state_reg)
            ST_CLR_EMIT:
                push = out_free;
            ST_EMIT_LO:
            begin
                push      = chg_lo_reg && out_free;
                push_idx  = widx_lo_reg[11:0];
                push_val  = new_lo_reg;
                push_last = !chg_hi_reg;
            end
            ST_EMIT_HI:
            begin
                push      = chg_hi_reg && out_free;
                push_idx  = widx_hi_reg[11:0];
                push_val  = new_hi_reg;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (push)
            out_valid_reg <= 1'b1;
        else if (dst.ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            out_idx_reg  <= push_idx;
            out_val_reg  <= push_val;
            out_last_reg <= push_last;
        end
    end

    assign dst.valid      = out_valid_reg;
    assign dst.word_addr  = out_idx_reg;
    assign dst.word_value = out_val_reg;
    assign dst.last_write = out_last_reg;

    // ---------------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------------
    `CMBW_ASSERT_IMP(a_single_port, mem_we, !mem_re)
    `CMBW_ASSERT_NXT(a_byte_starts_geom, in_fire && src.opcode == OP_BYTE, state_reg == ST_GEOM)
    `CMBW_ASSERT_NXT(a_not_last_has_more, push && !push_last, state_reg == ST_EMIT_HI && chg_hi_reg)
    `CMBW_ASSERT_IMP(a_write_has_cause, mem_we && state_reg != ST_INIT, push || in_fire)

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for the clipped mask bitmap writer.
`timescale 1ns / 1ps

module tb_top;
    import cmbw_pkg::*;

    localparam int MASK_W          = MASK_WIDTH_DEF;
    localparam int MASK_H          = MASK_HEIGHT_DEF;
    localparam int ROW_W           = ROW_WORDS_DEF;
    localparam int MASK_N          = MASK_WORDS_DEF;
    localparam int STALL_LIMIT     = 20000;
    localparam int SETTLE_CYCLES   = 12;
    localparam int HOLD_OFF_CYCLES = 300;

    typedef struct {
        word_idx_t word_addr;
        word_t     word_value;
        logic      last_write;
    } mask_write_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    cmbw_byte_if src_if ();
    cmbw_word_if dst_if ();

    // Local copy of the mask and the blit position.
    word_t              mask_copy [MASK_N];
    logic [12:0]        row_pos;
    logic [9:0]         byte_pos;
    logic signed [12:0] cfg_dest_x;
    logic signed [12:0] cfg_dest_y;
    logic [13:0]        cfg_width;
    logic [12:0]        cfg_height;
    logic [10:0]        cfg_stride;

    mask_write_t awaited_writes [$];
    mask_write_t oldest_write;
    int          mismatch_count;
    int          sent_items;
    int          stalled_cycles;
    int          feed_idle_pct;
    int          drain_idle_pct;
    int          stall_hold_cycles;
    int          hold_off_requests;
    int          hold_off_served;

    clipped_mask_bitmap_writer u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .src     (src_if),
        .dst     (dst_if)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Places one source byte into the mask copy and queues the words that change.
    function automatic void place_byte_pixels(logic restart, src_byte_t pixels);
        int          dy;
        int          dx;
        int          col;
        int          k;
        int          slot;
        int          used;
        int          stride;
        int unsigned widx;
        int unsigned slot_idx [2];
        word_t       slot_val [2];
        bit          row_ok;
        mask_write_t changed [$];
        mask_write_t w;

        used = 0;
        if (restart)
        begin
            row_pos = '0;
            byte_pos = '0;
        end
        dy = int'(cfg_dest_y) + int'(row_pos);
        row_ok = (cfg_width != 0) && (row_pos < cfg_height) && (dy >= 0) && (dy < MASK_H);
        for (k = 0; row_ok && k < 8; k++)
        begin
            col = int'(byte_pos) * 8 + k;
            if (col >= int'(cfg_width))
                break;
            dx = int'(cfg_dest_x) + col;
            if (dx < 0 || dx >= MASK_W)
                continue;
            widx = dy * ROW_W + dx / 32;
            if (widx >= MASK_N)
                continue;
            slot = 0;
            while (slot < used && slot_idx[slot] != widx)
                slot++;
            if (slot == used)
            begin
                if (used == 2)
                    continue;
                slot_idx[slot] = widx;
                slot_val[slot] = mask_copy[widx];
                used++;
            end
            slot_val[slot][dx % 32] = pixels[7 - k];
        end

        for (k = 0; k < used; k++)
        begin
            if (slot_val[k] != mask_copy[slot_idx[k]])
            begin
                mask_copy[slot_idx[k]] = slot_val[k];
                w.word_addr = word_idx_t'(slot_idx[k]);
                w.word_value = slot_val[k];
                w.last_write = 1'b0;
                changed.push_back(w);
            end
        end
        if (changed.size() > 0)
            changed[changed.size() - 1].last_write = 1'b1;
        foreach (changed[i])
            awaited_writes.push_back(changed[i]);

        stride = (cfg_stride == 0) ? 1 : ((cfg_stride > 1024) ? 1024 : int'(cfg_stride));
        if (int'(byte_pos) + 1 >= stride)
        begin
            byte_pos = '0;
            if (row_pos < 13'd8191)
                row_pos = row_pos + 1'b1;
        end
        else
        begin
            byte_pos = byte_pos + 1'b1;
        end
    endfunction

    function automatic void zero_mask_word(word_idx_t idx);
        mask_write_t w;

        mask_copy[idx] = '0;
        w.word_addr = idx;
        w.word_value = '0;
        w.last_write = 1'b1;
        awaited_writes.push_back(w);
    endfunction

    task automatic report_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s", msg);
    endtask

    task automatic send_item(logic op, logic restart, src_byte_t pixels, word_idx_t idx);
        @(negedge clk);
        while ($urandom_range(99) < feed_idle_pct)
        begin
            src_if.valid = 1'b0;
            @(negedge clk);
        end
        src_if.valid = 1'b1;
        src_if.opcode = op;
        src_if.first_byte = restart;
        src_if.source_byte = pixels;
        src_if.clear_index = idx;
        do
            @(posedge clk);
        while (src_if.ready !== 1'b1);
        if (op == OP_CLEAR)
            zero_mask_word(idx);
        else
            place_byte_pixels(restart, pixels);
        sent_items++;
    endtask

    task automatic send_byte(logic restart, src_byte_t pixels);
        send_item(OP_BYTE, restart, pixels, word_idx_t'($urandom));
    endtask

    task automatic send_clear(word_idx_t idx);
        send_item(OP_CLEAR, 1'($urandom_range(1)), src_byte_t'($urandom), idx);
    endtask

    // Waits until the block has nothing in flight, so registers may be written.
    task automatic settle_block();
        @(negedge clk);
        src_if.valid = 1'b0;
        while (awaited_writes.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(logic [2:0] reg_idx, logic [31:0] value);
        @(negedge clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {reg_idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        do
            @(posedge clk);
        while (pready !== 1'b1);
        case (reg_idx)
            REG_DEST_X:        cfg_dest_x = value[12:0];
            REG_DEST_Y:        cfg_dest_y = value[12:0];
            REG_BITMAP_WIDTH:  cfg_width  = value[13:0];
            REG_BITMAP_HEIGHT: cfg_height = value[12:0];
            REG_ROW_STRIDE:    cfg_stride = value[10:0];
            default:           ;
        endcase
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic set_geometry(int x, int y, int w, int h, int s);
        settle_block();
        write_register(REG_DEST_X, x & 'h1FFF);
        write_register(REG_DEST_Y, y & 'h1FFF);
        write_register(REG_BITMAP_WIDTH, w & 'h3FFF);
        write_register(REG_BITMAP_HEIGHT, h & 'h1FFF);
        write_register(REG_ROW_STRIDE, s & 'h7FF);
    endtask

    task automatic test_basic_rows();
        set_geometry(0, 0, 16, 2, 2);
        send_byte(1'b1, 8'hFF);
        // The second byte leaves its word as it was, so no write comes out.
        send_byte(1'b0, 8'h00);
        send_byte(1'b0, 8'hAA);
        send_byte(1'b0, 8'h55);
        send_clear(12'd0);
        send_clear(12'd4095);
    endtask

    task automatic test_clipped_edges();
        // Left columns fall off the mask, the fifth byte straddles two words,
        // the sixth is row padding and the next row lies below the mask.
        set_geometry(-4, 127, 40, 3, 6);
        send_byte(1'b1, 8'hF0);
        send_byte(1'b0, 8'h0F);
        send_byte(1'b0, 8'hCC);
        send_byte(1'b0, 8'h33);
        send_byte(1'b0, 8'hAA);
        send_byte(1'b0, 8'h55);
        send_byte(1'b0, 8'hFF);
    endtask

    task automatic test_right_edge_and_stride();
        // A zero stride acts as one byte per row.
        set_geometry(1020, -1, 8192, 2, 0);
        send_byte(1'b1, 8'hFF);
        send_byte(1'b0, 8'hFF);
        send_byte(1'b0, 8'hFF);
        set_geometry(4095, 4095, 16383, 8191, 2047);
        send_byte(1'b1, 8'hFF);
        set_geometry(-4096, -4096, 0, 0, 1);
        send_byte(1'b1, 8'hFF);
    endtask

    task automatic test_empty_bitmap();
        set_geometry(0, 0, 0, 4, 1);
        send_byte(1'b1, 8'hFF);
        send_byte(1'b0, 8'hFF);
        set_geometry(0, 0, 8, 0, 1);
        send_byte(1'b1, 8'hFF);
    endtask

    task automatic test_output_stall();
        set_geometry(0, 40, 64, 4, 8);
        hold_off_requests++;
        for (int i = 0; i < 24; i++)
        begin
            if (i % 3 == 2)
                send_clear(word_idx_t'(40 * ROW_W + i % 4));
            else
                send_byte(i == 0, src_byte_t'($urandom) | 8'h81);
        end
    endtask

    task automatic run_random_blits(int target);
        int        start_count;
        int        x;
        int        y;
        int        w;
        int        h;
        int        s;
        int        stride_eff;
        int        nbytes;
        int        near_row;
        int        near_col;
        logic      restart;
        src_byte_t pixels;

        start_count = sent_items;
        while (sent_items - start_count < target)
        begin
            if ($urandom_range(99) < 80)
            begin
                w = $urandom_range(1, 72);
                h = $urandom_range(1, 6);
                s = (w + 7) / 8 + $urandom_range(0, 2);
                x = $urandom_range(0, 1100) - 60;
                y = $urandom_range(0, 135) - 4;
            end
            else
            begin
                case ($urandom_range(4))
                    0:       x = -4096;
                    1:       x = 4095;
                    2:       x = -8;
                    3:       x = 1020;
                    default: x = $urandom_range(8191) - 4096;
                endcase
                case ($urandom_range(4))
                    0:       y = -4096;
                    1:       y = 4095;
                    2:       y = -1;
                    3:       y = 127;
                    default: y = $urandom_range(8191) - 4096;
                endcase
                case ($urandom_range(4))
                    0:       w = 0;
                    1:       w = 8192;
                    2:       w = 16383;
                    3:       w = 1;
                    default: w = $urandom_range(16383);
                endcase
                case ($urandom_range(4))
                    0:       h = 0;
                    1:       h = 4096;
                    2:       h = 8191;
                    3:       h = 1;
                    default: h = $urandom_range(8191);
                endcase
                case ($urandom_range(4))
                    0:       s = 0;
                    1:       s = 1;
                    2:       s = 1024;
                    3:       s = 2047;
                    default: s = $urandom_range(2047);
                endcase
            end
            set_geometry(x, y, w, h, s);

            stride_eff = (s == 0) ? 1 : ((s > 1024) ? 1024 : s);
            // Sometimes one row past the bottom of the bitmap is sent as well.
            nbytes = stride_eff * (((h > 6) ? 6 : h) + $urandom_range(0, 1));
            if (nbytes > 48)
                nbytes = 48;
            if (nbytes == 0)
                nbytes = 4;
            near_row = (y < 0) ? 0 : ((y >= MASK_H) ? MASK_H - 1 : y);
            near_col = (x < 0) ? 0 : ((x >= MASK_W) ? MASK_W - 1 : x);

            for (int n = 0; n < nbytes; n++)
            begin
                if ($urandom_range(99) < 8)
                begin
                    if ($urandom_range(1) == 0)
                        send_clear(word_idx_t'(near_row * ROW_W + near_col / 32
                                               + $urandom_range(0, 2)));
                    else
                        send_clear(word_idx_t'($urandom));
                end
                // A missing restart at the start or a stray one mid-bitmap
                // makes a broken sequence now and then.
                restart = (n == 0) ? ($urandom_range(99) >= 5) : ($urandom_range(99) == 0);
                case ($urandom_range(9))
                    0:       pixels = 8'h00;
                    1:       pixels = 8'hFF;
                    default: pixels = src_byte_t'($urandom);
                endcase
                send_byte(restart, pixels);
            end
        end
    endtask

    task automatic finish_run();
        settle_block();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && awaited_writes.size() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    endtask

    // Output side: random idling, plus a long hold-off when one is requested.
    always @(negedge clk)
    begin
        if (hold_off_requests != hold_off_served)
        begin
            hold_off_served = hold_off_requests;
            stall_hold_cycles = HOLD_OFF_CYCLES;
        end
        if (stall_hold_cycles > 0)
        begin
            dst_if.ready = 1'b0;
            stall_hold_cycles = stall_hold_cycles - 1;
        end
        else
        begin
            dst_if.ready = ($urandom_range(99) >= drain_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && dst_if.valid === 1'b1 && dst_if.ready === 1'b1)
        begin
            if (awaited_writes.size() == 0)
            begin
                report_mismatch($sformatf("unexpected mask write: word %0d value %08h last %0b",
                                          dst_if.word_addr, dst_if.word_value,
                                          dst_if.last_write));
            end
            else
            begin
                oldest_write = awaited_writes.pop_front();
                if (dst_if.word_addr !== oldest_write.word_addr
                    || dst_if.word_value !== oldest_write.word_value
                    || dst_if.last_write !== oldest_write.last_write)
                begin
                    report_mismatch($sformatf(
                        "mismatch: exp word %0d val %08h last %0b, got word %0d val %08h last %0b",
                        oldest_write.word_addr, oldest_write.word_value,
                        oldest_write.last_write, dst_if.word_addr, dst_if.word_value,
                        dst_if.last_write));
                end
            end
        end
    end

    // Any transaction on either channel or the register port counts as progress.
    always @(posedge clk)
    begin
        if ((src_if.valid === 1'b1 && src_if.ready === 1'b1)
            || (dst_if.valid === 1'b1 && dst_if.ready === 1'b1)
            || (psel === 1'b1 && penable === 1'b1 && pready === 1'b1))
            stalled_cycles = 0;
        else
            stalled_cycles = stalled_cycles + 1;
        if (stalled_cycles >= STALL_LIMIT)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial
    begin
        src_if.valid = 1'b0;
        src_if.opcode = OP_BYTE;
        src_if.first_byte = 1'b0;
        src_if.source_byte = '0;
        src_if.clear_index = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        rst_n = 1'b0;
        foreach (mask_copy[i])
            mask_copy[i] = '0;
        row_pos = '0;
        byte_pos = '0;
        cfg_dest_x = '0;
        cfg_dest_y = '0;
        cfg_width = '0;
        cfg_height = '0;
        cfg_stride = 11'd1;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        feed_idle_pct = 37;
        drain_idle_pct = 80;
        test_basic_rows();
        test_clipped_edges();
        test_right_edge_and_stride();
        test_empty_bitmap();
        test_output_stall();
        run_random_blits(620);

        feed_idle_pct = 80;
        drain_idle_pct = 37;
        run_random_blits(620);

        feed_idle_pct = 0;
        drain_idle_pct = 0;
        run_random_blits(620);

        finish_run();
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/cmbw_pkg.sv
hdl/cmbw_byte_if.sv
hdl/cmbw_word_if.sv
hdl/clipped_mask_bitmap_writer.sv
tb/tb_top.sv
